// ----- rtl/core/des_pkg.sv -----
// DES constants and permutation / S-box functions shared by the encryptor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package des_pkg;

    localparam int BlockW = 64;
    localparam int KeyW   = 64;
    localparam int RkW    = 48;
    localparam int Rounds = 16;
    localparam int RndW   = 4;
    localparam int CfgIdxW = 2;

    typedef enum logic [2:0] {
        MODE_ECB = 3'd0,
        MODE_CBC = 3'd1,
        MODE_CFB = 3'd2,
        MODE_OFB = 3'd3,
        MODE_CTR = 3'd4
    } mode_t;

    localparam logic [CfgIdxW-1:0] REG_KEY  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MODE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_IV   = 2'd2;

    localparam logic [7:0] T_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [7:0] T_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [7:0] T_EXP [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam logic [7:0] T_PBOX [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam logic [7:0] T_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [7:0] T_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    localparam logic [15:0] ROT_TWO = 16'b0111111011111100; // bit i: round i shifts by two

    localparam logic [3:0] T_SBOX [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(T_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(T_FP[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(T_PC1[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(T_PC2[i])];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(T_EXP[i])];
        e = e ^ k;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = T_SBOX[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(T_PBOX[i])];
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/des_round.sv -----
// One DES round with on-the-fly key schedule: rotate C/D, PC-2, Feistel.
// Depends on des_pkg.
`timescale 1ns / 1ps
`default_nettype none
module des_feistel_step
    import des_pkg::*;
(
    input  wire logic [RndW-1:0] rnd,
    input  wire logic [55:0]     cd_in,
    input  wire logic [63:0]     lr_in,
    output logic [55:0]          cd_out,
    output logic [63:0]          lr_out
);
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] rk;

    always_comb
    begin
        if (ROT_TWO[rnd])
        begin
            c = {cd_in[53:28], cd_in[55:54]};
            d = {cd_in[25:0], cd_in[27:26]};
        end
        else
        begin
            c = {cd_in[54:28], cd_in[55]};
            d = {cd_in[26:0], cd_in[27]};
        end
        cd_out = {c, d};
        rk     = perm_pc2(cd_out);
        lr_out = {lr_in[31:0], lr_in[63:32] ^ feistel(lr_in[31:0], rk)};
    end
endmodule
`default_nettype wire

// ----- rtl/core/des_block_encrypt_modes.sv -----
// Top level: DES encryptor with ECB/CBC/CFB/OFB/CTR chaining.
// Depends on des_pkg and des_feistel_step.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 key, 1 mode, 2 IV)
//   and cfg_data. cfg_ready is always high; write only while idle.
//   Input: in_valid/in_ready carries plain_block and first_block. A request
//   is taken only in IDLE; the block then runs one shared round unit, one
//   DES round per cycle up to the last round, with the key schedule rotated
//   alongside it, so no stored round-key table is needed.
//   Output: out_valid/out_ready carries cipher_block from an output
//   register; out_valid rises as the last round's result lands there. The
//   block is ready again the cycle after the last round, taking a new
//   request only after the previous one retires. The output register parts the
//   two sides: a result waiting on a stalled receiver does not block the
//   next request, which runs its rounds and then holds after the last round
//   until the output register drains; no request is taken during that hold.
//   Reset clears key, mode, IV, feedback register and all handshake state.
//   Unused mode codes behave as ECB: feedback takes the IV on a first block.
module des_block_encrypt_modes
    import des_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [63:0]        plain_block,
    input  wire logic               first_block,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             cipher_block
);
    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t          state_reg;
    logic [RndW-1:0] rnd_reg;
    logic [63:0]     key_reg;
    logic [2:0]      mode_reg;
    logic [63:0]     iv_reg;
    logic [63:0]     fb_reg;
    logic [63:0]     plain_reg;
    logic [55:0]     cd_reg;
    logic [63:0]     lr_reg;
    logic [63:0]     out_reg;
    logic            out_valid_reg;

    logic [55:0]     cd_next;
    logic [63:0]     lr_next;
    logic [63:0]     fb_use;
    logic [63:0]     din;
    logic [63:0]     enc;
    logic [63:0]     res;
    logic            last_rnd;
    logic            out_free;
    logic            finish;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cipher_block = out_reg;

    // the last round may only retire once the output register is free
    assign last_rnd = (rnd_reg == RndW'(Rounds - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (state_reg == ST_RUN) && last_rnd && out_free;

    des_feistel_step u_round (
        .rnd    (rnd_reg),
        .cd_in  (cd_reg),
        .lr_in  (lr_reg),
        .cd_out (cd_next),
        .lr_out (lr_next)
    );

    // Pick the cipher input from mode and feedback at acceptance, and form the result by mode.
    always_comb
    begin
        fb_use = first_block ? iv_reg : fb_reg;
        case (mode_reg) inside
            MODE_CBC:                     din = plain_block ^ fb_use;
            MODE_CFB, MODE_OFB, MODE_CTR: din = fb_use;
            default:                      din = plain_block;
        endcase
        enc = perm_fp({lr_next[31:0], lr_next[63:32]});
        case (mode_reg) inside
            MODE_CFB, MODE_OFB, MODE_CTR: res = plain_reg ^ enc;
            default:                      res = enc;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            key_reg       <= '0;
            mode_reg      <= '0;
            iv_reg        <= '0;
            fb_reg        <= '0;
            plain_reg     <= '0;
            cd_reg        <= '0;
            lr_reg        <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_KEY:  key_reg  <= cfg_data;
                    REG_MODE: mode_reg <= cfg_data[2:0];
                    REG_IV:   iv_reg   <= cfg_data;
                    default:  ;
                endcase
            end
            // raise valid on a fresh result, drop it once the receiver takes it
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        fb_reg    <= first_block ? iv_reg : fb_reg;
                        plain_reg <= plain_block;
                        cd_reg    <= perm_pc1(key_reg);
                        lr_reg    <= perm_ip(din);
                        rnd_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (!last_rnd)
                    begin
                        // advance one round per cycle through the shared unit
                        cd_reg  <= cd_next;
                        lr_reg  <= lr_next;
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        out_reg   <= res;
                        rnd_reg   <= '0;
                        state_reg <= ST_IDLE;
                        case (mode_reg) inside
                            MODE_CBC, MODE_CFB: fb_reg <= res;
                            MODE_OFB:           fb_reg <= enc;
                            MODE_CTR:           fb_reg <= fb_reg + 64'd1;
                            default:            ;
                        endcase
                    end
                    // otherwise hold the last round until the output drains
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
